@@ sv/round_robin_quantum_scheduler_top_defines.svh @@
// ----------------------------------------------------------------------------
// round robin quantum scheduler assertion macros
// shared concurrent assertion forms on clk_i / rst_ni
// ----------------------------------------------------------------------------
`ifndef ROUND_ROBIN_QUANTUM_SCHEDULER_TOP_DEFINES_SVH
`define ROUND_ROBIN_QUANTUM_SCHEDULER_TOP_DEFINES_SVH

// checked only while out of reset
`define RRQS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// checked at every edge, reset included
`define RRQS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

@@ sv/rrqs_pkg.sv @@
// ----------------------------------------------------------------------------
// rrqs_pkg
// shared types, codes and defaults of the round robin quantum scheduler
// ----------------------------------------------------------------------------
package rrqs_pkg;

  localparam int NumCpusDef      = 4;
  localparam int QueueDepthDef   = 16;
  localparam int ThreadIdBitsDef = 8;

  localparam logic [7:0] QuantumRst = 8'd5;

  // event kinds
  localparam logic [1:0] KIND_ENQUEUE = 2'd0;
  localparam logic [1:0] KIND_TICK    = 2'd1;
  localparam logic [1:0] KIND_YIELD   = 2'd2;
  localparam logic [1:0] KIND_PREEMPT = 2'd3;

  // result status codes
  localparam logic [2:0] ST_DONE      = 3'd0;
  localparam logic [2:0] ST_SWITCHED  = 3'd1;
  localparam logic [2:0] ST_STARTED   = 3'd2;
  localparam logic [2:0] ST_SAME      = 3'd3;
  localparam logic [2:0] ST_EMPTY     = 3'd4;
  localparam logic [2:0] ST_DROPPED   = 3'd5;
  localparam logic [2:0] ST_NO_ACTION = 3'd6;

  typedef struct packed {
    logic [1:0] kind;
    logic [2:0] cpu;
    logic [7:0] thread_id;
    logic       prev_requeue;
  } event_t;

  typedef struct packed {
    logic [2:0] status;
    logic [7:0] next_thread;
    logic [7:0] prev_thread;
    logic       prev_valid;
    logic       resched_pending;
  } result_t;

endpackage

@@ sv/rrqs_ram.sv @@
// ----------------------------------------------------------------------------
// rrqs_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module rrqs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ sv/round_robin_quantum_scheduler_top.sv @@
// ----------------------------------------------------------------------------
// round robin quantum scheduler
// per-cpu run queues, time slice counting and thread switching.
// an event transaction is taken at a clock edge with start_i high and busy_o
// low; busy_o stays low, so one transaction can enter in every cycle.
// kinds: enqueue a thread, tick, yield, preempt check (yields if flagged).
// the event is registered together with a snapshot of its cpu's state and
// the run queue entry at that cpu's head (read from the queue ram at accept
// time, with a bypass of a write made in the same cycle). the result
// register loads from the execute logic in the cycle after the accept, so
// result_valid_o is high for exactly one cycle per result. throughput is
// one transaction per cycle, set by the single ram read port that is used
// once per event. per-cpu state updates feed forward into the snapshot of
// the next event, so back-to-back events on one cpu are exact. the receiver
// cannot stall: a result is lost if not taken on its cycle. reset:
// quantum 5, all queues empty, cpu 0 runs thread 0, counters and reschedule
// flags clear. queue ram contents are not cleared and no sweep runs; only
// pushed entries are ever popped. the user writes quantum through cfg_we_i
// and cfg_wdata_i only while no event is in flight; unchecked by the block.
// ----------------------------------------------------------------------------
`include "round_robin_quantum_scheduler_top_defines.svh"

module round_robin_quantum_scheduler_top #(
  parameter int NUM_CPUS       = rrqs_pkg::NumCpusDef,
  parameter int QUEUE_DEPTH    = rrqs_pkg::QueueDepthDef,
  parameter int THREAD_ID_BITS = rrqs_pkg::ThreadIdBitsDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  rrqs_pkg::event_t  item_i,
  output logic              result_valid_o,
  output rrqs_pkg::result_t result_o,
  input  logic              cfg_we_i,
  input  logic [7:0]        cfg_wdata_i
);
  import rrqs_pkg::*;

  localparam int CpuW     = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
  localparam int HeadW    = $clog2(QUEUE_DEPTH);
  localparam int CntW     = $clog2(QUEUE_DEPTH + 1);
  localparam int TidW     = THREAD_ID_BITS;
  localparam int MemDepth = NUM_CPUS * QUEUE_DEPTH;
  localparam int AddrW    = $clog2(MemDepth);

  // configuration
  logic [7:0] quantum_q;

  // per-cpu state, one lane per cpu
  logic [HeadW-1:0] head_q [NUM_CPUS];
  logic [HeadW-1:0] head_d [NUM_CPUS];
  logic [CntW-1:0]  cnt_q  [NUM_CPUS];
  logic [CntW-1:0]  cnt_d  [NUM_CPUS];
  logic [TidW-1:0]  cur_q  [NUM_CPUS];
  logic [TidW-1:0]  cur_d  [NUM_CPUS];
  logic             curv_q [NUM_CPUS];
  logic             curv_d [NUM_CPUS];
  logic [7:0]       tick_q [NUM_CPUS];
  logic [7:0]       tick_d [NUM_CPUS];
  logic             rsch_q [NUM_CPUS];
  logic             rsch_d [NUM_CPUS];

  // accept side
  logic              accept;
  logic              oor;
  logic [CpuW-1:0]   cpu_n;
  logic [TidW+7:0]   tid_ext;
  logic [AddrW-1:0]  raddr;

  // execute stage registers
  logic              s1_valid_q;
  logic              s1_ign_q;
  logic [1:0]        s1_kind_q;
  logic [CpuW-1:0]   s1_cpu_q;
  logic [TidW-1:0]   s1_id_q;
  logic              s1_req_q;
  logic [HeadW-1:0]  s1_head_q;
  logic [CntW-1:0]   s1_cnt_q;
  logic [TidW-1:0]   s1_cur_q;
  logic              s1_curv_q;
  logic [7:0]        s1_tick_q;
  logic              s1_rsch_q;
  logic              byp_q;
  logic [TidW-1:0]   byp_data_q;

  // execute stage logic
  logic              upd;
  logic [TidW-1:0]   ram_rdata;
  logic [TidW-1:0]   pop_id;
  logic [HeadW-1:0]  head_inc;
  logic [CntW:0]     tail_sum;
  logic [CntW:0]     tail_wrap;
  logic [HeadW-1:0]  tail_slot;
  logic [7:0]        tick_inc;
  logic              yield_go;
  logic [HeadW-1:0]  new_head;
  logic [CntW-1:0]   new_cnt;
  logic [TidW-1:0]   new_cur;
  logic              new_curv;
  logic [7:0]        new_tick;
  logic              new_rsch;
  logic [2:0]        new_status;
  logic              mem_we;
  logic [AddrW-1:0]  waddr;
  logic [TidW-1:0]   wdata;
  logic [TidW+7:0]   next_ext;
  logic [TidW+7:0]   prev_ext;
  result_t           res_d;

  // result register
  logic              res_valid_q;
  result_t           res_q;

  // result classes seen by the checks
  logic              res_switch;
  logic              res_yielded;
  logic              sw_distinct;

  // --------------------------------------------------------------------------
  // accept: choose the cpu lane and read its queue head
  // --------------------------------------------------------------------------
  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  // out-of-range cpu: enqueue goes to cpu 0, other kinds do nothing
  assign oor     = 32'(item_i.cpu) >= NUM_CPUS;
  assign cpu_n   = oor ? '0 : item_i.cpu[CpuW-1:0];
  assign tid_ext = {{TidW{1'b0}}, item_i.thread_id};
  assign raddr   = AddrW'(32'(cpu_n) * 32'(QUEUE_DEPTH) + 32'(head_d[cpu_n]));

  rrqs_ram #(
    .WIDTH (TidW),
    .DEPTH (MemDepth)
  ) u_queue_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (accept),
    .raddr_i (raddr),
    .rdata_o (ram_rdata)
  );

  // --------------------------------------------------------------------------
  // execute: one event on the snapshot of its cpu
  // --------------------------------------------------------------------------
  assign upd    = s1_valid_q && !s1_ign_q;
  assign pop_id = byp_q ? byp_data_q : ram_rdata;

  assign head_inc  = (s1_head_q == HeadW'(QUEUE_DEPTH - 1)) ? '0 : s1_head_q + 1'b1;
  assign tail_sum  = (CntW+1)'(s1_head_q) + (CntW+1)'(s1_cnt_q);
  assign tail_wrap = (tail_sum >= (CntW+1)'(QUEUE_DEPTH)) ?
                     tail_sum - (CntW+1)'(QUEUE_DEPTH) : tail_sum;
  assign tail_slot = tail_wrap[HeadW-1:0];
  assign tick_inc  = s1_tick_q + 8'd1;
  assign yield_go  = (s1_kind_q == KIND_YIELD) ||
                     ((s1_kind_q == KIND_PREEMPT) && s1_rsch_q);

  always_comb begin
    new_head   = s1_head_q;
    new_cnt    = s1_cnt_q;
    new_cur    = s1_cur_q;
    new_curv   = s1_curv_q;
    new_tick   = s1_tick_q;
    new_rsch   = s1_rsch_q;
    new_status = ST_DONE;
    mem_we     = 1'b0;
    case (s1_kind_q)
      KIND_ENQUEUE: begin
        if (s1_cnt_q == CntW'(QUEUE_DEPTH)) begin
          new_status = ST_DROPPED;
        end else begin
          mem_we  = 1'b1;
          new_cnt = s1_cnt_q + 1'b1;
        end
      end
      KIND_TICK: begin
        // end of slice: flag only if someone is waiting
        if (tick_inc >= quantum_q) begin
          new_tick = '0;
          if (s1_cnt_q != '0) begin
            new_rsch = 1'b1;
          end
        end else begin
          new_tick = tick_inc;
        end
      end
      KIND_YIELD, KIND_PREEMPT: begin
        if (!yield_go) begin
          new_status = ST_NO_ACTION;
        end else begin
          new_rsch = 1'b0;
          if (s1_cnt_q == '0) begin
            new_status = ST_EMPTY;
          end else begin
            new_head = head_inc;
            new_cnt  = s1_cnt_q - 1'b1;
            if (s1_curv_q && (s1_cur_q == pop_id)) begin
              new_status = ST_SAME;
            end else if (!s1_curv_q) begin
              new_cur    = pop_id;
              new_curv   = 1'b1;
              new_status = ST_STARTED;
            end else begin
              // requeue lands in the old tail slot, count stays
              if (s1_req_q) begin
                mem_we  = 1'b1;
                new_cnt = s1_cnt_q;
              end
              new_cur    = pop_id;
              new_status = ST_SWITCHED;
            end
          end
        end
      end
      default: begin
        new_status = ST_NO_ACTION;
      end
    endcase
    if (!upd) begin
      mem_we = 1'b0;
    end
  end

  // enqueue writes its own id, a requeue writes the old current thread
  assign wdata = (s1_kind_q == KIND_ENQUEUE) ? s1_id_q : s1_cur_q;
  assign waddr = AddrW'(32'(s1_cpu_q) * 32'(QUEUE_DEPTH) + 32'(tail_slot));

  assign next_ext = {8'd0, (new_curv ? new_cur : '0)};
  assign prev_ext = {8'd0, (s1_curv_q ? s1_cur_q : '0)};

  always_comb begin
    if (s1_ign_q) begin
      res_d                 = '0;
      res_d.status          = ST_NO_ACTION;
    end else begin
      res_d.status          = new_status;
      res_d.next_thread     = next_ext[7:0];
      res_d.prev_thread     = prev_ext[7:0];
      res_d.prev_valid      = s1_curv_q;
      res_d.resched_pending = new_rsch;
    end
  end

  // --------------------------------------------------------------------------
  // per-cpu lanes: each takes the update when the event is its own
  // --------------------------------------------------------------------------
  always_comb begin
    for (int i = 0; i < NUM_CPUS; i++) begin
      if (upd && (s1_cpu_q == CpuW'(i))) begin
        head_d[i] = new_head;
        cnt_d[i]  = new_cnt;
        cur_d[i]  = new_cur;
        curv_d[i] = new_curv;
        tick_d[i] = new_tick;
        rsch_d[i] = new_rsch;
      end else begin
        head_d[i] = head_q[i];
        cnt_d[i]  = cnt_q[i];
        cur_d[i]  = cur_q[i];
        curv_d[i] = curv_q[i];
        tick_d[i] = tick_q[i];
        rsch_d[i] = rsch_q[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_CPUS; i++) begin
        head_q[i] <= '0;
        cnt_q[i]  <= '0;
        cur_q[i]  <= '0;
        curv_q[i] <= (i == 0);
        tick_q[i] <= '0;
        rsch_q[i] <= 1'b0;
      end
      quantum_q   <= QuantumRst;
      s1_valid_q  <= 1'b0;
      byp_q       <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      for (int i = 0; i < NUM_CPUS; i++) begin
        head_q[i] <= head_d[i];
        cnt_q[i]  <= cnt_d[i];
        cur_q[i]  <= cur_d[i];
        curv_q[i] <= curv_d[i];
        tick_q[i] <= tick_d[i];
        rsch_q[i] <= rsch_d[i];
      end
      if (cfg_we_i) begin
        quantum_q <= cfg_wdata_i;
      end
      s1_valid_q  <= accept;
      res_valid_q <= s1_valid_q;
      if (accept) begin
        // a write to the slot being read this cycle wins over the ram
        byp_q <= mem_we && (waddr == raddr);
      end
    end
  end

  // event, snapshot and result registers, payload only
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_ign_q   <= oor && (item_i.kind != KIND_ENQUEUE);
      s1_kind_q  <= item_i.kind;
      s1_cpu_q   <= cpu_n;
      s1_id_q    <= tid_ext[TidW-1:0];
      s1_req_q   <= item_i.prev_requeue;
      s1_head_q  <= head_d[cpu_n];
      s1_cnt_q   <= cnt_d[cpu_n];
      s1_cur_q   <= cur_d[cpu_n];
      s1_curv_q  <= curv_d[cpu_n];
      s1_tick_q  <= tick_d[cpu_n];
      s1_rsch_q  <= rsch_d[cpu_n];
      byp_data_q <= wdata;
    end
    if (s1_valid_q) begin
      res_q <= res_d;
    end
  end

  assign result_valid_o = res_valid_q;
  assign result_o       = res_q;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  assign res_switch  = result_valid_o && (result_o.status == ST_SWITCHED);
  assign res_yielded = result_valid_o &&
                       (result_o.status inside {ST_SWITCHED, ST_STARTED, ST_SAME, ST_EMPTY});
  assign sw_distinct = result_o.prev_valid && (result_o.next_thread != result_o.prev_thread);

  `RRQS_ASSERT(a_result_follows, s1_valid_q |=> result_valid_o, "result strobe missing")
  `RRQS_ASSERT(a_cnt_bound, s1_valid_q |-> (s1_cnt_q <= CntW'(QUEUE_DEPTH)), "count overflow")
  `RRQS_ASSERT(a_switch_prev, res_switch |-> sw_distinct, "switch without distinct thread")
  `RRQS_ASSERT(a_yield_clears, res_yielded |-> !result_o.resched_pending, "flag set after yield")
  `RRQS_ASSERT(a_bypass_src, $rose(byp_q) |-> $past(mem_we), "bypass without a queue write")
  `RRQS_ASSERT_ALWAYS(a_reset_quiet, !rst_ni |-> !result_valid_o, "result strobe during reset")

endmodule
